// ===== src/sce_pkg.sv =====
// ----------------------------------------------------------------------------
// sce_pkg
// Shared constants and types for the sensor change event extractor.
// ----------------------------------------------------------------------------
package sce_pkg;

   localparam int SCAN_BYTES = 10;
   localparam int POS_W      = $clog2(SCAN_BYTES);
   localparam int BYTE_W     = 8;
   localparam int LIMIT_W    = 7;
   localparam int KEEP_W     = 4;
   localparam int MOD_W      = 3;
   localparam int NUM_W      = 5;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

   localparam logic [LIMIT_W-1:0] LIMIT_RESET      = 7'd16;
   localparam logic [NUM_W-1:0]   SENSORS_PER_BYTE = 5'd8;

   // one classified word handed from front to back
   typedef struct packed {
      logic [BYTE_W-1:0] diff;   // changed bits
      logic [BYTE_W-1:0] level;  // new byte
      logic [POS_W-1:0]  pos;
      logic [KEEP_W-1:0] keep;   // events allowed from this word
      logic              eor;    // final word of a scan that recorded events
   } entry_type;

endpackage

// ===== src/sce_front.sv =====
// ----------------------------------------------------------------------------
// sce_front
// Accepts report words, compares with the previous scan, applies the limit.
// ----------------------------------------------------------------------------
module sce_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [sce_pkg::BYTE_W-1:0]  req_sensor_byte,
   input  logic                        csr_wr_en,
   input  logic [sce_pkg::LIMIT_W-1:0] csr_wr_data,
   input  logic                        fifo_full,
   output logic                        fifo_push,
   output sce_pkg::entry_type          fifo_entry
);

   logic [sce_pkg::BYTE_W-1:0]  prev_ff [sce_pkg::SCAN_BYTES];
   logic [sce_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [sce_pkg::LIMIT_W-1:0] count_ff, count_in;
   logic [sce_pkg::LIMIT_W-1:0] limit_ff;

   logic [sce_pkg::BYTE_W-1:0]  diff;
   logic [sce_pkg::KEEP_W-1:0]  pop_cnt;
   logic [sce_pkg::LIMIT_W-1:0] room;
   logic [sce_pkg::KEEP_W-1:0]  keep;
   logic [sce_pkg::LIMIT_W:0]   count_sum;
   logic                        final_word;
   logic                        accept;

   assign req_stall = fifo_full;
   assign accept    = req_valid && !fifo_full;

   always_comb begin
      diff    = prev_ff[pos_ff] ^ req_sensor_byte;
      pop_cnt = '0;
      for (int i = 0; i < sce_pkg::BYTE_W; i++) begin
         pop_cnt = pop_cnt + sce_pkg::KEEP_W'(diff[i]);
      end
      room = (count_ff < limit_ff) ? limit_ff - count_ff : '0;
      keep = (room < sce_pkg::LIMIT_W'(pop_cnt)) ? room[sce_pkg::KEEP_W-1:0] : pop_cnt;
      count_sum  = {1'b0, count_ff} + (sce_pkg::LIMIT_W + 1)'(keep);
      final_word = (pos_ff == sce_pkg::POS_W'(sce_pkg::SCAN_BYTES - 1));

      if (final_word) begin
         pos_in   = '0;
         count_in = '0;
      end else begin
         pos_in   = pos_ff + 1'b1;
         count_in = count_sum[sce_pkg::LIMIT_W-1:0];
      end

      fifo_push        = accept;
      fifo_entry.diff  = diff;
      fifo_entry.level = req_sensor_byte;
      fifo_entry.pos   = pos_ff;
      fifo_entry.keep  = keep;
      fifo_entry.eor   = final_word && (count_sum != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         count_ff <= '0;
         limit_ff <= sce_pkg::LIMIT_RESET;
         for (int i = 0; i < sce_pkg::SCAN_BYTES; i++) begin
            prev_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (accept) begin
            pos_ff          <= pos_in;
            count_ff        <= count_in;
            prev_ff[pos_ff] <= req_sensor_byte;
         end
      end
   end

endmodule

// ===== src/sce_fifo.sv =====
// ----------------------------------------------------------------------------
// sce_fifo
// Short show-ahead queue between the front and the back.
// ----------------------------------------------------------------------------
module sce_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sce_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output sce_pkg::entry_type head,
   output logic               empty
);

   sce_pkg::entry_type              mem_ff [sce_pkg::FIFO_DEPTH];
   logic [sce_pkg::FIFO_PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [sce_pkg::FIFO_PTR_W:0]    fill_ff, fill_in;
   logic                            do_push, do_pop;

   assign full    = (fill_ff == (sce_pkg::FIFO_PTR_W + 1)'(sce_pkg::FIFO_DEPTH));
   assign empty   = (fill_ff == '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      fill_in = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== src/sce_back.sv =====
// ----------------------------------------------------------------------------
// sce_back
// Serializes the allowed changed bits of each queued word into event results.
// ----------------------------------------------------------------------------
module sce_back (
   input  logic                       clock,
   input  logic                       reset,
   input  sce_pkg::entry_type         head,
   input  logic                       empty,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_event_valid,
   output logic [sce_pkg::MOD_W-1:0]  rsp_module_index,
   output logic [sce_pkg::NUM_W-1:0]  rsp_sensor_number,
   output logic                       rsp_is_on,
   output logic                       rsp_last_in_item,
   output logic                       rsp_end_of_report
);

   logic [sce_pkg::BYTE_W-1:0] done_ff, done_in;
   logic [sce_pkg::KEEP_W-1:0] sent_ff, sent_in;

   logic                       valid_ff, valid_in;
   logic                       ev_ff, ev_in;
   logic [sce_pkg::MOD_W-1:0]  mod_ff, mod_in;
   logic [sce_pkg::NUM_W-1:0]  num_ff, num_in;
   logic                       on_ff, on_in;
   logic                       last_ff, last_in;
   logic                       eor_ff, eor_in;

   logic [sce_pkg::BYTE_W-1:0] remaining;
   logic [2:0]                 bit_sel;
   logic                       out_free;
   logic                       load;
   logic                       last_event;

   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      remaining = head.diff & ~done_ff;
      bit_sel   = '0;
      // lowest changed bit not yet sent
      for (int i = sce_pkg::BYTE_W - 1; i >= 0; i--) begin
         if (remaining[i]) begin
            bit_sel = 3'(i);
         end
      end
      last_event = (sce_pkg::KEEP_W'(sent_ff + 1'b1) == head.keep);

      pop     = 1'b0;
      load    = 1'b0;
      done_in = done_ff;
      sent_in = sent_ff;
      ev_in   = ev_ff;
      mod_in  = mod_ff;
      num_in  = num_ff;
      on_in   = on_ff;
      last_in = last_ff;
      eor_in  = eor_ff;

      if (!empty) begin
         if (head.keep == '0) begin
            if (!head.eor) begin
               pop = 1'b1;
            end else if (out_free) begin
               // marker-only word
               pop     = 1'b1;
               load    = 1'b1;
               ev_in   = 1'b0;
               mod_in  = '0;
               num_in  = '0;
               on_in   = 1'b0;
               last_in = 1'b1;
               eor_in  = 1'b1;
            end
         end else if (out_free) begin
            load    = 1'b1;
            ev_in   = 1'b1;
            mod_in  = sce_pkg::MOD_W'(head.pos >> 1);
            num_in  = (sce_pkg::SENSORS_PER_BYTE - sce_pkg::NUM_W'(bit_sel))
                      + (head.pos[0] ? sce_pkg::SENSORS_PER_BYTE : '0);
            on_in   = head.level[bit_sel];
            last_in = last_event;
            eor_in  = last_event && head.eor;
            if (last_event) begin
               pop     = 1'b1;
               done_in = '0;
               sent_in = '0;
            end else begin
               done_in = done_ff | (sce_pkg::BYTE_W'(1) << bit_sel);
               sent_in = sent_ff + 1'b1;
            end
         end
      end

      if (load) begin
         valid_in = 1'b1;
      end else if (out_free) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         done_ff  <= '0;
         sent_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         done_ff  <= done_in;
         sent_ff  <= sent_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_ff   <= ev_in;
      mod_ff  <= mod_in;
      num_ff  <= num_in;
      on_ff   <= on_in;
      last_ff <= last_in;
      eor_ff  <= eor_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_event_valid   = ev_ff;
   assign rsp_module_index  = mod_ff;
   assign rsp_sensor_number = num_ff;
   assign rsp_is_on         = on_ff;
   assign rsp_last_in_item  = last_ff;
   assign rsp_end_of_report = eor_ff;

endmodule

// ===== src/sensor_change_event_extractor.sv =====
// ----------------------------------------------------------------------------
// sensor_change_event_extractor
// Turns scanned sensor report words into per-sensor change events.
// ----------------------------------------------------------------------------
// An accepted word is queued first; its results are then registered at the output.
// Throughput: one word per cycle into a four-entry queue while it is not full;
// the back end sends one result per cycle unless rsp_stall holds it, up to 8
// per word. The back end's serializer sets the sustained rate.
// Reset: synchronous; previous scan cleared to zero, position and count zero,
// event limit 16, queue and output empty.
module sensor_change_event_extractor (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [sce_pkg::BYTE_W-1:0]  req_sensor_byte,
   input  logic                        csr_wr_en,
   input  logic [sce_pkg::LIMIT_W-1:0] csr_wr_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_event_valid,
   output logic [sce_pkg::MOD_W-1:0]   rsp_module_index,
   output logic [sce_pkg::NUM_W-1:0]   rsp_sensor_number,
   output logic                        rsp_is_on,
   output logic                        rsp_last_in_item,
   output logic                        rsp_end_of_report
);

   sce_pkg::entry_type push_entry;
   sce_pkg::entry_type head;
   logic               push, full, pop, empty;

   sce_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sensor_byte (req_sensor_byte),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .fifo_full       (full),
      .fifo_push       (push),
      .fifo_entry      (push_entry)
   );

   sce_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head       (head),
      .empty      (empty)
   );

   sce_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .empty             (empty),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_valid   (rsp_event_valid),
      .rsp_module_index  (rsp_module_index),
      .rsp_sensor_number (rsp_sensor_number),
      .rsp_is_on         (rsp_is_on),
      .rsp_last_in_item  (rsp_last_in_item),
      .rsp_end_of_report (rsp_end_of_report)
   );

endmodule

// ===== bench/sensor_change_event_extractor_tb.sv =====
// ----------------------------------------------------------------------------
// sensor_change_event_extractor_tb
// Self-checking bench: drives report words through whole scans under several
// event limits, tracks the previous scan in a local predictor and checks every
// change event and end marker, with random idling on both sides.
// ----------------------------------------------------------------------------
module sensor_change_event_extractor_tb;

   localparam int STALL_LIMIT = 2000;   // cycles with no handshake at all
   localparam int SETTLE      = 16;     // queue depth plus pipeline, rounded up
   localparam int LONG_HOLD   = 200;

   typedef struct packed {
      logic                        event_valid;
      logic [sce_pkg::MOD_W-1:0]   module_index;
      logic [sce_pkg::NUM_W-1:0]   sensor_number;
      logic                        is_on;
      logic                        last_in_item;
      logic                        end_of_report;
   } sensor_event_type;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic [sce_pkg::BYTE_W-1:0]   req_sensor_byte;
   logic                         csr_wr_en;
   logic [sce_pkg::LIMIT_W-1:0]  csr_wr_data;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic                         rsp_event_valid;
   logic [sce_pkg::MOD_W-1:0]    rsp_module_index;
   logic [sce_pkg::NUM_W-1:0]    rsp_sensor_number;
   logic                         rsp_is_on;
   logic                         rsp_last_in_item;
   logic                         rsp_end_of_report;

   // predictor state
   logic [sce_pkg::BYTE_W-1:0]   last_scan [sce_pkg::SCAN_BYTES];
   int                           scan_pos;
   int                           scan_count;
   int                           limit_now;
   sensor_event_type             expected_events [$];

   int errors       = 0;
   int words_sent   = 0;
   int results_seen = 0;
   int markers_seen = 0;
   int limit_writes = 0;
   int hold_cycles  = 0;
   int send_idle    = 1;
   int recv_idle    = 1;

   sensor_change_event_extractor uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sensor_byte   (req_sensor_byte),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_valid   (rsp_event_valid),
      .rsp_module_index  (rsp_module_index),
      .rsp_sensor_number (rsp_sensor_number),
      .rsp_is_on         (rsp_is_on),
      .rsp_last_in_item  (rsp_last_in_item),
      .rsp_end_of_report (rsp_end_of_report)
   );

   always #10 clock = ~clock;

   // 0: no idling, 1: a random gap before every word, 2: occasional gaps
   function automatic int pick_gap(input int level);
      if (level == 0)
         return 0;
      if (level == 1 || $urandom_range(0, 3) == 0)
         return $urandom_range(0, 13);
      return 0;
   endfunction

   task automatic report_error(input string msg);
      errors++;
      $display("ERROR at %0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         report_error($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   // expected results of one accepted word; updates the scan image
   function automatic void predict_word(input logic [sce_pkg::BYTE_W-1:0] now);
      sensor_event_type           batch [0:8];
      logic [sce_pkg::BYTE_W-1:0] old;
      int                         pos;
      int                         n;
      n   = 0;
      pos = (scan_pos >= sce_pkg::SCAN_BYTES) ? 0 : scan_pos;
      old = last_scan[pos];
      last_scan[pos] = now;
      for (int j = 0; j < sce_pkg::BYTE_W; j++) begin
         if (old[j] != now[j] && scan_count < limit_now) begin
            batch[n] = '0;
            batch[n].event_valid   = 1'b1;
            batch[n].module_index  = sce_pkg::MOD_W'(pos / 2);
            batch[n].sensor_number = sce_pkg::NUM_W'(8 - j + 8 * (pos % 2));
            batch[n].is_on         = now[j];
            scan_count++;
            n++;
         end
      end
      if (pos == sce_pkg::SCAN_BYTES - 1) begin
         if (scan_count > 0) begin
            if (n == 0) begin
               // no events from this word: marker stands alone
               batch[0] = '0;
               n = 1;
               markers_seen++;
            end
            batch[n-1].end_of_report = 1'b1;
         end
         scan_count = 0;
         scan_pos   = 0;
      end else begin
         scan_pos = pos + 1;
      end
      if (n > 0)
         batch[n-1].last_in_item = 1'b1;
      for (int k = 0; k < n; k++)
         expected_events.push_back(batch[k]);
   endfunction

   // returns at the accepting edge with valid still high
   task automatic send_word(input logic [sce_pkg::BYTE_W-1:0] data);
      int gap;
      gap = pick_gap(send_idle);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_sensor_byte <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_word(data);
      words_sent++;
   endtask

   // mostly small edits of the stored byte so that counts build up unevenly
   function automatic logic [sce_pkg::BYTE_W-1:0] next_word();
      logic [sce_pkg::BYTE_W-1:0] prev;
      prev = last_scan[scan_pos];
      case ($urandom_range(0, 5))
         0: return sce_pkg::BYTE_W'($urandom);
         1: return prev;
         2: return prev ^ (8'h01 << $urandom_range(0, 7));
         3: return ~prev;
         4: return prev ^ sce_pkg::BYTE_W'($urandom & $urandom);
         default: return $urandom_range(0, 1) ? 8'h00 : 8'hFF;
      endcase
   endfunction

   task automatic send_scans(input int count);
      repeat (count * sce_pkg::SCAN_BYTES) send_word(next_word());
   endtask

   // idle the input and let every queued word run out
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_limit(input logic [sce_pkg::LIMIT_W-1:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      limit_now = value;
      limit_writes++;
      csr_wr_en <= 1'b0;
   endtask

   task automatic check_result();
      sensor_event_type want;
      results_seen++;
      if (expected_events.size() == 0) begin
         report_error($sformatf("unexpected result ev=%0b mod=%0d num=%0d on=%0b",
                                rsp_event_valid, rsp_module_index,
                                rsp_sensor_number, rsp_is_on));
      end else begin
         want = expected_events.pop_front();
         check_field("event_valid", rsp_event_valid, want.event_valid);
         check_field("module_index", rsp_module_index, want.module_index);
         check_field("sensor_number", rsp_sensor_number, want.sensor_number);
         check_field("is_on", rsp_is_on, want.is_on);
         check_field("last_in_item", rsp_last_in_item, want.last_in_item);
         check_field("end_of_report", rsp_end_of_report, want.end_of_report);
      end
   endtask

   // receiver: owns rsp_stall
   initial begin
      int gap;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end else begin
            gap = pick_gap(recv_idle);
            if (gap > 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid && hold_cycles == 0) @(posedge clock);
         if (rsp_valid)
            check_result();
      end
   end

   initial begin
      int stale;
      stale = 0;
      while (stale < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            stale = 0;
         else
            stale++;
      end
      $display("FAIL");
      $finish;
   end

   // empty scan first, then a scan that hits the reset limit of 16 and ends
   // with only dropped changes, so a bare marker closes it
   task automatic test_directed_scans();
      logic [sce_pkg::BYTE_W-1:0] second [sce_pkg::SCAN_BYTES];
      second = '{8'hFF, 8'hFF, 8'h55, 8'hAA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80};
      send_idle = 1;
      recv_idle = 1;
      repeat (sce_pkg::SCAN_BYTES) send_word(8'h00);
      for (int i = 0; i < sce_pkg::SCAN_BYTES; i++)
         send_word(second[i]);
   endtask

   // limit one, the top of range, zero (nothing ever reported) and above range
   task automatic test_limit_extremes();
      logic [sce_pkg::LIMIT_W-1:0] limits [4];
      limits = '{7'd1, 7'd80, 7'd0, 7'd127};
      for (int i = 0; i < 4; i++) begin
         set_limit(limits[i]);
         send_idle = $urandom_range(0, 2);
         recv_idle = $urandom_range(0, 2);
         send_scans(limits[i] == 0 ? 2 : 3);
      end
   endtask

   // output held off while words keep coming, so the input queue backs up
   task automatic test_backpressure();
      set_limit(7'd80);
      send_idle   = 0;
      recv_idle   = 0;
      hold_cycles = LONG_HOLD;
      send_scans(3);
      recv_idle = 2;
   endtask

   task automatic test_random_traffic();
      for (int i = 0; i < 7; i++) begin
         set_limit(sce_pkg::LIMIT_W'($urandom_range(1, 80)));
         send_idle = $urandom_range(0, 2);
         recv_idle = $urandom_range(0, 2);
         send_scans(4);
      end
   endtask

   initial begin
      for (int i = 0; i < sce_pkg::SCAN_BYTES; i++)
         last_scan[i] = '0;
      scan_pos        = 0;
      scan_count      = 0;
      limit_now       = sce_pkg::LIMIT_RESET;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_sensor_byte <= '0;
      csr_wr_en       <= 1'b0;
      csr_wr_data     <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_scans();
      test_limit_extremes();
      test_backpressure();
      test_random_traffic();
      drain();

      $display("Sent %0d words (%0d scans); checked %0d results, %0d bare end markers.",
               words_sent, words_sent / sce_pkg::SCAN_BYTES, results_seen, markers_seen);
      $display("Event limit written %0d times incl. 0, 1, 80, 127; one long output hold-off.",
               limit_writes);
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
